@@ hw/rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue: result codes,
// field widths and the command and status words between controller and
// datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int PRIO_W     = 16;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int PAY_PORT_W = 32;
  localparam int CAP_W      = 7;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_EMPTY   = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_BADKIND   = 3'd2,
    ST_EXTRACTED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } command_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    ins_start;
    logic    up_read;
    logic    up_move;
    logic    ext_read;
    logic    ext_load;
    logic    dn_read;
    logic    dn_move;
    logic    put_m;
    logic    emit;
    status_e emit_code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_extract;
    logic full;
    logic bad_kind;
    logic empty;
    logic at_root;
    logic up_win;
    logic dn_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/max_heap_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of tagged tasks with insert and extract commands.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; command_i selects an
// insert (priority, kind and payload) or an extract of the highest entry.
// Each word gives exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall, so the result must be taken in that cycle.
// Dropped inserts and an extract on an empty heap report straight from the
// decide state without touching the entry memory. A stored insert sifts up
// level by level until it reaches the root or a parent that is not smaller;
// an extract reads the last entry, moves it to the root and sifts it down
// level by level. Each level is a read step then a compare-and-write step on
// the entry memory. busy stays high until the result is out, and one word is
// worked on at a time. The capacity register is written through cfg_valid_i
// and cfg_data_i; the user must do so only while the block is idle, which the
// block does not enforce. cfg_ready_o is always high. Reset empties the heap
// and sets the capacity to 64; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit #(
  parameter int HEAP_DEPTH    = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic signed [mhpq_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [mhpq_pkg::KIND_W-1:0]          kind_i,
  input  logic [mhpq_pkg::PAY_PORT_W-1:0]      payload_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mhpq_pkg::CAP_W-1:0]           cfg_data_i,
  output logic                                 done_o,
  output logic [mhpq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [mhpq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [mhpq_pkg::KIND_W-1:0]          out_kind_o,
  output logic [mhpq_pkg::PAY_PORT_W-1:0]      out_payload_o
);
  import mhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mhpq_dp #(
    .HEAP_DEPTH    (HEAP_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (command_i),
    .priority_req_i (priority_req_i),
    .kind_i         (kind_i),
    .payload_i      (payload_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_kind_o     (out_kind_o),
    .out_payload_o  (out_payload_o)
  );

endmodule

@@ hw/rtl/mhpq_dp.sv @@
// ----------------------------------------------------------------------------
// mhpq_dp
// Datapath of the heap: entry memory with one write and two read ports,
// entry count, capacity register, moving entry, hole index and result word.
// ----------------------------------------------------------------------------
module mhpq_dp #(
  parameter int HEAP_DEPTH    = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mhpq_pkg::dp_cmd_t                    cmd_i,
  output mhpq_pkg::dp_stat_t                   stat_o,
  input  logic                                 command_i,
  input  logic signed [mhpq_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [mhpq_pkg::KIND_W-1:0]          kind_i,
  input  logic [mhpq_pkg::PAY_PORT_W-1:0]      payload_i,
  input  logic                                 cfg_valid_i,
  input  logic [mhpq_pkg::CAP_W-1:0]           cfg_data_i,
  output logic                                 done_o,
  output logic [mhpq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [mhpq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [mhpq_pkg::KIND_W-1:0]          out_kind_o,
  output logic [mhpq_pkg::PAY_PORT_W-1:0]      out_payload_o
);
  import mhpq_pkg::*;

  localparam int AW   = $clog2(HEAP_DEPTH);
  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int IW   = AW + 2;

  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic                      kbit;
    logic [PAYLOAD_WIDTH-1:0]  data;
  } entry_t;

  entry_t heap_mem [HEAP_DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [CW-1:0]     count_q;
  logic              done_q;
  logic [AW-1:0]     hole_q;
  entry_t            mov_q;
  entry_t            top_q;
  entry_t            rd0_q;
  entry_t            rd1_q;
  logic              is_ext_q;
  logic              bad_kind_q;
  status_e           status_q;
  logic [PRIO_W-1:0] oprio_q;
  logic [KIND_W-1:0] okind_q;
  logic [PAY_PORT_W-1:0] opay_q;

  logic [AW-1:0]     raddr0;
  logic [AW-1:0]     raddr1;
  logic              we;
  entry_t            wdata;
  logic [AW-1:0]     parent;
  logic [AW:0]       lch;
  logic [AW:0]       rch;
  logic [CW-1:0]     cnt_m1;
  logic              l_better;
  logic              r_better;
  logic signed [PRIO_W-1:0] best_prio;
  logic [PAYLOAD_WIDTH+PAY_PORT_W-1:0] pay_in_ext;
  logic [PAYLOAD_WIDTH+PAY_PORT_W-1:0] pay_out_ext;

  assign parent = AW'(hole_q - AW'(1)) >> 1;
  assign lch    = {hole_q, 1'b1};
  assign rch    = {hole_q, 1'b0} + (AW + 1)'(2);
  assign cnt_m1 = count_q - CW'(1);

  assign pay_in_ext  = {{PAYLOAD_WIDTH{1'b0}}, payload_i};
  assign pay_out_ext = {{PAY_PORT_W{1'b0}}, top_q.data};

  // Sift-down choice: the left child wins ties against the right one, and a
  // child only moves up when strictly greater than the moving entry.
  always_comb begin
    l_better  = (IW'(lch) < IW'(count_q)) && (rd0_q.prio > mov_q.prio);
    best_prio = l_better ? rd0_q.prio : mov_q.prio;
    r_better  = (IW'(rch) < IW'(count_q)) && (rd1_q.prio > best_prio);
  end

  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    if (cmd_i.up_read) begin
      raddr0 = parent;
    end
    if (cmd_i.ext_read) begin
      raddr1 = cnt_m1[AW-1:0];
    end
    if (cmd_i.dn_read) begin
      raddr0 = lch[AW-1:0];
      raddr1 = rch[AW-1:0];
    end
  end

  always_comb begin
    we    = cmd_i.put_m | cmd_i.up_move | cmd_i.dn_move;
    wdata = mov_q;
    if (cmd_i.up_move) begin
      wdata = rd0_q;
    end else if (cmd_i.dn_move) begin
      wdata = r_better ? rd1_q : rd0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[hole_q] <= wdata;
    end
    rd0_q <= heap_mem[raddr0];
    rd1_q <= heap_mem[raddr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.ins_start) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.ext_load) begin
        count_q <= cnt_m1;
      end
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_ext_q      <= command_i;
      bad_kind_q    <= kind_i[1];
      mov_q.prio    <= priority_req_i;
      mov_q.kbit    <= kind_i[0];
      mov_q.data    <= pay_in_ext[PAYLOAD_WIDTH-1:0];
    end
    if (cmd_i.ins_start) begin
      hole_q <= count_q[AW-1:0];
    end else if (cmd_i.up_move) begin
      hole_q <= parent;
    end else if (cmd_i.ext_load) begin
      hole_q <= '0;
      top_q  <= rd0_q;
      mov_q  <= rd1_q;
    end else if (cmd_i.dn_move) begin
      hole_q <= r_better ? rch[AW-1:0] : lch[AW-1:0];
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_code;
      case (cmd_i.emit_code)
        ST_EXTRACTED: begin
          oprio_q <= top_q.prio;
          okind_q <= {1'b0, top_q.kbit};
          opay_q  <= pay_out_ext[PAY_PORT_W-1:0];
        end
        ST_EMPTY: begin
          oprio_q <= PRIO_EMPTY;
          okind_q <= KIND_INVALID;
          opay_q  <= '0;
        end
        default: begin
          oprio_q <= '0;
          okind_q <= '0;
          opay_q  <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.is_extract = (is_ext_q == CMD_EXTRACT);
    stat_o.full       = (count_q >= CW'(HEAP_DEPTH)) ||
                        (CMPW'(count_q) >= CMPW'(cap_q));
    stat_o.bad_kind   = bad_kind_q;
    stat_o.empty      = (count_q == '0);
    stat_o.at_root    = (hole_q == '0);
    stat_o.up_win     = (rd0_q.prio < mov_q.prio);
    stat_o.dn_done    = !l_better && !r_better;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = oprio_q;
  assign out_kind_o     = okind_q;
  assign out_payload_o  = opay_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  a_ext_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ext_load |=> count_q == $past(count_q) - CW'(1))
    else $error("extract did not remove exactly one entry");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_start |-> (count_q < CW'(HEAP_DEPTH)) &&
                        (CMPW'(count_q) < CMPW'(cap_q)))
    else $error("insert started on a full heap");

endmodule

@@ hw/rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Controller of the heap: decides each word, then steps the sift-up or
// sift-down level by level (read state, compare state) and issues the result.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mhpq_pkg::dp_stat_t stat_i,
  output mhpq_pkg::dp_cmd_t  cmd_o
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_EXT_LOAD,
    S_DN_RD,
    S_DN_CMP
  } state_e;

  state_e  state_q;
  state_e  state_d;
  logic    busy_q;
  dp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (start && !busy_q) begin
          cmd.capture = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.is_extract) begin
          if (stat_i.empty) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_EMPTY;
            state_d       = S_IDLE;
          end else begin
            cmd.ext_read = 1'b1;
            state_d      = S_EXT_LOAD;
          end
        end else if (stat_i.full) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_FULL;
          state_d       = S_IDLE;
        end else if (stat_i.bad_kind) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_BADKIND;
          state_d       = S_IDLE;
        end else begin
          cmd.ins_start = 1'b1;
          state_d       = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd.put_m     = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_INSERTED;
          state_d       = S_IDLE;
        end else begin
          cmd.up_read = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_win) begin
          cmd.up_move = 1'b1;
          state_d     = S_UP_RD;
        end else begin
          cmd.put_m     = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_INSERTED;
          state_d       = S_IDLE;
        end
      end
      S_EXT_LOAD: begin
        cmd.ext_load = 1'b1;
        state_d      = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_read = 1'b1;
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_done) begin
          cmd.put_m     = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_EXTRACTED;
          state_d       = S_IDLE;
        end else begin
          cmd.dn_move = 1'b1;
          state_d     = S_DN_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy  = busy_q;
  assign cmd_o = cmd;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> busy_q)
    else $error("busy not raised after a word was taken");

  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cmd.emit))
    else $error("work ended without a result");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after a result");

endmodule
